### design/bde_pkg.sv
// Shared types, constants and helper functions of the boolean dissimilarity engine.
`timescale 1ns / 1ps
`default_nettype none
package bde_pkg;

	localparam int WORD_W      = 32;
	localparam int LANE_CNT_W  = 6;
	localparam int DIST_W      = 18;
	localparam int CNT_OUT_W   = 16;
	localparam int GROUP_SIZE  = 8;
	localparam int GRP_CNT_W   = 4;
	localparam int NUM_CLASSES = 4;
	localparam int METRIC_W    = 3;
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 2;

	localparam int DEF_LANES       = 32;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// pair classes
	localparam int CLS_TT = 0;
	localparam int CLS_TF = 1;
	localparam int CLS_FT = 2;
	localparam int CLS_FF = 3;

	typedef enum logic [METRIC_W-1:0] {
		M_HAMMING   = 3'd0,
		M_JACCARD   = 3'd1,
		M_DICE      = 3'd2,
		M_YULE      = 3'd3,
		M_ROGERS    = 3'd4,
		M_RUSSELL   = 3'd5,
		M_KULSINSKI = 3'd6,
		M_SOKAL     = 3'd7
	} metric_t;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MUL_A,
		ST_MUL_B,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic valid;
		logic last;
	} pair_ctl_t;

	typedef struct packed {
		logic valid;
		logic ovf;
	} tally_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// lanes that really exist: the input word carries at most WORD_W pairs
	function automatic int eff_lanes(input int lanes);
		return (lanes < WORD_W) ? lanes : WORD_W;
	endfunction

	function automatic int num_groups(input int lanes);
		return (eff_lanes(lanes) + GROUP_SIZE - 1) / GROUP_SIZE;
	endfunction

endpackage
`default_nettype wire

### design/bde_ifs.sv
// Valid/ready channel interfaces for the word input and the result output.
`timescale 1ns / 1ps
`default_nettype none
interface bde_in_if;
	logic                               valid;
	logic                               ready;
	logic [bde_pkg::WORD_W-1:0]         u_bits;
	logic [bde_pkg::WORD_W-1:0]         v_bits;
	logic [bde_pkg::LANE_CNT_W-1:0]     lane_count;
	logic                               last_word;

	modport source (output valid, u_bits, v_bits, lane_count, last_word, input ready);
	modport sink (input valid, u_bits, v_bits, lane_count, last_word, output ready);
endinterface

interface bde_out_if;
	logic                               valid;
	logic                               ready;
	logic [bde_pkg::DIST_W-1:0]         distance;
	logic                               undefined;
	logic                               overflow;
	logic [bde_pkg::CNT_OUT_W-1:0]      count_tt;
	logic [bde_pkg::CNT_OUT_W-1:0]      count_tf;
	logic [bde_pkg::CNT_OUT_W-1:0]      count_ft;
	logic [bde_pkg::CNT_OUT_W-1:0]      count_ff;

	modport source (output valid, distance, undefined, overflow,
		count_tt, count_tf, count_ft, count_ff, input ready);
	modport sink (input valid, distance, undefined, overflow,
		count_tt, count_tf, count_ft, count_ff, output ready);
endinterface
`default_nettype wire

### design/bde_lanes.sv
// Per-lane pair classification and group counts, registered into stage 1.
`timescale 1ns / 1ps
`default_nettype none
module bde_lanes #(
	parameter int LANES = bde_pkg::DEF_LANES
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire logic [bde_pkg::WORD_W-1:0]             u_bits,
	input  wire logic [bde_pkg::WORD_W-1:0]             v_bits,
	input  wire logic [bde_pkg::LANE_CNT_W-1:0]         lane_count,
	input  wire logic                                   last_word,
	output bde_pkg::pair_ctl_t                          ctl,
	output logic [bde_pkg::NUM_CLASSES-1:0][bde_pkg::num_groups(LANES)-1:0]
		[bde_pkg::GRP_CNT_W-1:0]                        grp_cnt
);

	localparam int EL = bde_pkg::eff_lanes(LANES);
	localparam int NG = bde_pkg::num_groups(LANES);
	localparam int PADW = NG * bde_pkg::GROUP_SIZE;

	logic [bde_pkg::NUM_CLASSES-1:0][PADW-1:0] cls;
	logic [bde_pkg::NUM_CLASSES-1:0][NG-1:0][bde_pkg::GRP_CNT_W-1:0] grp_d;
	logic [bde_pkg::NUM_CLASSES-1:0][NG-1:0][bde_pkg::GRP_CNT_W-1:0] grp_s1;
	bde_pkg::pair_ctl_t ctl_s1;

	// one-hot class per lane; lanes at or above lane_count stay empty
	always_comb begin
		cls = '0;
		for (int i = 0; i < EL; i++) begin
			if (lane_count > bde_pkg::LANE_CNT_W'(i)) begin
				cls[bde_pkg::CLS_TT][i] = u_bits[i] & v_bits[i];
				cls[bde_pkg::CLS_TF][i] = u_bits[i] & ~v_bits[i];
				cls[bde_pkg::CLS_FT][i] = ~u_bits[i] & v_bits[i];
				cls[bde_pkg::CLS_FF][i] = ~u_bits[i] & ~v_bits[i];
			end
		end
	end

	always_comb begin
		grp_d = '0;
		for (int c = 0; c < bde_pkg::NUM_CLASSES; c++) begin
			for (int g = 0; g < NG; g++) begin
				for (int j = 0; j < bde_pkg::GROUP_SIZE; j++) begin
					grp_d[c][g] = grp_d[c][g] +
						bde_pkg::GRP_CNT_W'(cls[c][g*bde_pkg::GROUP_SIZE+j]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.last  <= accept & last_word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1 <= grp_d;
		end
	end

	assign ctl     = ctl_s1;
	assign grp_cnt = grp_s1;

endmodule
`default_nettype wire

### design/bde_tally.sv
// Merge of the group counts and the four saturating pair tallies.
`timescale 1ns / 1ps
`default_nettype none
module bde_tally #(
	parameter int LANES       = bde_pkg::DEF_LANES,
	parameter int COUNT_WIDTH = bde_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  bde_pkg::pair_ctl_t                          ctl,
	input  wire logic [bde_pkg::NUM_CLASSES-1:0][bde_pkg::num_groups(LANES)-1:0]
		[bde_pkg::GRP_CNT_W-1:0]                        grp_cnt,
	output bde_pkg::tally_stat_t                        stat,
	output logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH-1:0] fin_cnt
);

	localparam int NG = bde_pkg::num_groups(LANES);

	logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH-1:0]  tally_q;
	logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH-1:0]  tally_new;
	logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH-1:0]  fin_q;
	logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH:0]    sum;
	logic [bde_pkg::NUM_CLASSES-1:0][bde_pkg::LANE_CNT_W-1:0] inc;
	logic sat_q;
	logic sat_hit;
	bde_pkg::tally_stat_t stat_q;

	always_comb begin
		sat_hit   = 1'b0;
		inc       = '0;
		sum       = '0;
		tally_new = '0;
		for (int c = 0; c < bde_pkg::NUM_CLASSES; c++) begin
			for (int g = 0; g < NG; g++) begin
				inc[c] = inc[c] + bde_pkg::LANE_CNT_W'(grp_cnt[c][g]);
			end
			sum[c] = {1'b0, tally_q[c]} + (COUNT_WIDTH+1)'(inc[c]);
			// carry out means the sum passed the all-ones limit
			if (sum[c][COUNT_WIDTH]) begin
				tally_new[c] = '1;
				sat_hit      = 1'b1;
			end else begin
				tally_new[c] = sum[c][COUNT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			sat_q   <= 1'b0;
			stat_q  <= '0;
		end else begin
			stat_q.valid <= ctl.valid & ctl.last;
			if (ctl.valid) begin
				if (ctl.last) begin
					tally_q    <= '0;
					sat_q      <= 1'b0;
					stat_q.ovf <= sat_q | sat_hit;
				end else begin
					tally_q <= tally_new;
					sat_q   <= sat_q | sat_hit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid && ctl.last) begin
			fin_q <= tally_new;
		end
	end

	assign stat    = stat_q;
	assign fin_cnt = fin_q;

endmodule
`default_nettype wire

### design/bde_divider.sv
// Restoring fixed-point divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bde_divider #(
	parameter int OP_W      = 2 * bde_pkg::DEF_COUNT_WIDTH + 1,
	parameter int FRAC_BITS = bde_pkg::DEF_FRAC_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [OP_W-1:0]        num,
	input  wire logic [OP_W-1:0]        den,
	output logic [FRAC_BITS+1:0]        quotient,
	output bde_pkg::div_stat_t          stat
);

	localparam int DW   = OP_W + FRAC_BITS;
	localparam int QW   = FRAC_BITS + 2;
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [OP_W-1:0] rem_q;
	logic [OP_W-1:0] den_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic [OP_W:0]   trial;
	logic [OP_W:0]   diff;
	logic            fits;
	bde_pkg::div_stat_t stat_q;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			cnt_q  <= '0;
		end else begin
			stat_q.done <= 1'b0;
			if (start) begin
				stat_q.busy <= 1'b1;
				cnt_q       <= CNTW'(DW);
			end else if (stat_q.busy) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					stat_q.busy <= 1'b0;
					stat_q.done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {FRAC_BITS{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (stat_q.busy) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			// quotient never exceeds 2.0 in Q.FRAC_BITS, so high bits shifted out are zero
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign stat     = stat_q;

endmodule
`default_nettype wire

### design/boolean_dissimilarity_engine.sv
// Boolean dissimilarity engine top level: APB register, sequencer and result register.
// Words of up to 32 bit pairs are taken one per cycle; each lane sorts its pair into one
// of four classes, lane groups are counted in stage 1 and merged into saturating tallies
// in stage 2. After the word marked last the input stalls while the sequencer runs its
// shared multiplier in states MUL_A and MUL_B (yule terms), forms numerator and denominator
// in state LOAD and then waits on the bit-serial divider; the divider sets the per-vector
// cost until the next vector's first word can be taken. A finished result waits in an output
// register, so a new vector can stream in while it is still pending.
`timescale 1ns / 1ps
`default_nettype none
module boolean_dissimilarity_engine #(
	parameter int LANES       = bde_pkg::DEF_LANES,
	parameter int COUNT_WIDTH = bde_pkg::DEF_COUNT_WIDTH,
	parameter int FRAC_BITS   = bde_pkg::DEF_FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bde_in_if.sink                              in_ch,
	bde_out_if.source                           out_ch,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bde_pkg::APB_AW-1:0]     paddr,
	input  wire logic [bde_pkg::APB_DW-1:0]     pwdata,
	output logic [bde_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	localparam int NG   = bde_pkg::num_groups(LANES);
	localparam int OP_W = 2 * COUNT_WIDTH + 1;
	localparam int QW   = FRAC_BITS + 2;
	localparam int CMPW = (QW > bde_pkg::DIST_W) ? QW : bde_pkg::DIST_W;

	bde_pkg::metric_t     metric_q;
	bde_pkg::state_t      state_q, state_d;
	bde_pkg::pair_ctl_t   lane_ctl;
	bde_pkg::tally_stat_t fin;
	bde_pkg::div_stat_t   dstat;

	logic [bde_pkg::NUM_CLASSES-1:0][NG-1:0][bde_pkg::GRP_CNT_W-1:0] grp_cnt;
	logic [bde_pkg::NUM_CLASSES-1:0][COUNT_WIDTH-1:0] fin_cnt;

	logic in_accept;
	logic in_ready;
	logic div_start;
	logic out_load;

	logic [COUNT_WIDTH-1:0]   mul_x, mul_y;
	logic [2*COUNT_WIDTH-1:0] prod_ab_q, prod_cd_q;
	logic [OP_W-1:0] e_tt, e_tf, e_ft, e_ff, diff, n_all;
	logic [OP_W-1:0] num_d, den_d;
	logic            undef_q;
	logic [QW-1:0]   quotient;
	logic            dist_sat;

	logic                             out_valid_q;
	logic [bde_pkg::DIST_W-1:0]       out_dist_q;
	logic                             out_undef_q;
	logic                             out_ovf_q;
	logic [bde_pkg::NUM_CLASSES-1:0][bde_pkg::CNT_OUT_W-1:0] out_cnt_q;

	// configuration port: one register, byte offset ignored
	assign pready = 1'b1;
	assign prdata = {{(bde_pkg::APB_DW-bde_pkg::METRIC_W){1'b0}}, metric_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= bde_pkg::M_HAMMING;
		end else if (psel && penable && pwrite && pready && (paddr == '0 || paddr != '0)) begin
			metric_q <= bde_pkg::metric_t'(pwdata[bde_pkg::METRIC_W-1:0]);
		end
	end

	assign in_accept   = in_ch.valid & in_ready;
	assign in_ch.ready = in_ready;

	bde_lanes #(
		.LANES (LANES)
	) u_lanes (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.u_bits     (in_ch.u_bits),
		.v_bits     (in_ch.v_bits),
		.lane_count (in_ch.lane_count),
		.last_word  (in_ch.last_word),
		.ctl        (lane_ctl),
		.grp_cnt    (grp_cnt)
	);

	bde_tally #(
		.LANES       (LANES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lane_ctl),
		.grp_cnt (grp_cnt),
		.stat    (fin),
		.fin_cnt (fin_cnt)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bde_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			bde_pkg::ST_ACCUM: begin
				// hold off once a last word is in flight toward the tallies
				in_ready = !(lane_ctl.valid && lane_ctl.last) && !fin.valid;
				if (fin.valid) begin
					state_d = bde_pkg::ST_MUL_A;
				end
			end
			bde_pkg::ST_MUL_A: state_d = bde_pkg::ST_MUL_B;
			bde_pkg::ST_MUL_B: state_d = bde_pkg::ST_LOAD;
			bde_pkg::ST_LOAD: begin
				div_start = 1'b1;
				state_d   = bde_pkg::ST_DIV;
			end
			bde_pkg::ST_DIV: begin
				if (dstat.done) begin
					state_d = bde_pkg::ST_DONE;
				end
			end
			bde_pkg::ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = bde_pkg::ST_ACCUM;
				end
			end
			default: state_d = bde_pkg::ST_ACCUM;
		endcase
	end

	// shared multiplier: tf*ft, then tt*ff
	assign mul_x = (state_q == bde_pkg::ST_MUL_A) ? fin_cnt[bde_pkg::CLS_TF]
		: fin_cnt[bde_pkg::CLS_TT];
	assign mul_y = (state_q == bde_pkg::ST_MUL_A) ? fin_cnt[bde_pkg::CLS_FT]
		: fin_cnt[bde_pkg::CLS_FF];

	always_ff @(posedge clk) begin
		if (state_q == bde_pkg::ST_MUL_A) begin
			prod_ab_q <= mul_x * mul_y;
		end
		if (state_q == bde_pkg::ST_MUL_B) begin
			prod_cd_q <= mul_x * mul_y;
		end
	end

	assign e_tt  = OP_W'(fin_cnt[bde_pkg::CLS_TT]);
	assign e_tf  = OP_W'(fin_cnt[bde_pkg::CLS_TF]);
	assign e_ft  = OP_W'(fin_cnt[bde_pkg::CLS_FT]);
	assign e_ff  = OP_W'(fin_cnt[bde_pkg::CLS_FF]);
	assign diff  = e_tf + e_ft;
	assign n_all = e_tt + diff + e_ff;

	always_comb begin
		num_d = diff;
		den_d = n_all;
		case (metric_q)
			bde_pkg::M_HAMMING: begin
				num_d = diff;
				den_d = n_all;
			end
			bde_pkg::M_JACCARD: begin
				num_d = diff;
				den_d = e_tt + diff;
			end
			bde_pkg::M_DICE: begin
				num_d = diff;
				den_d = (e_tt << 1) + diff;
			end
			bde_pkg::M_YULE: begin
				num_d = {prod_ab_q, 1'b0};
				den_d = OP_W'(prod_cd_q) + OP_W'(prod_ab_q);
			end
			bde_pkg::M_ROGERS: begin
				num_d = diff << 1;
				den_d = e_tt + e_ff + (diff << 1);
			end
			bde_pkg::M_RUSSELL: begin
				num_d = n_all - e_tt;
				den_d = n_all;
			end
			bde_pkg::M_KULSINSKI: begin
				num_d = diff + n_all - e_tt;
				den_d = diff + n_all;
			end
			bde_pkg::M_SOKAL: begin
				num_d = diff << 1;
				den_d = (diff << 1) + e_tt;
			end
			default: begin
				num_d = diff;
				den_d = n_all;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			undef_q <= (den_d == '0);
		end
	end

	bde_divider #(
		.OP_W      (OP_W),
		.FRAC_BITS (FRAC_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_d),
		.den      (den_d),
		.quotient (quotient),
		.stat     (dstat)
	);

	assign dist_sat = CMPW'(quotient) > CMPW'(bde_pkg::DIST_MAX);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_undef_q <= undef_q;
			out_ovf_q   <= fin.ovf;
			if (undef_q) begin
				out_dist_q <= '0;
			end else if (dist_sat) begin
				out_dist_q <= bde_pkg::DIST_MAX;
			end else begin
				out_dist_q <= bde_pkg::DIST_W'(quotient);
			end
			for (int c = 0; c < bde_pkg::NUM_CLASSES; c++) begin
				out_cnt_q[c] <= bde_pkg::CNT_OUT_W'(fin_cnt[c]);
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.distance  = out_dist_q;
	assign out_ch.undefined = out_undef_q;
	assign out_ch.overflow  = out_ovf_q;
	assign out_ch.count_tt  = out_cnt_q[bde_pkg::CLS_TT];
	assign out_ch.count_tf  = out_cnt_q[bde_pkg::CLS_TF];
	assign out_ch.count_ft  = out_cnt_q[bde_pkg::CLS_FT];
	assign out_ch.count_ff  = out_cnt_q[bde_pkg::CLS_FF];

`ifndef NO_ASSERTIONS
	// a finished vector only reaches the sequencer while it is accumulating
	a_fin_in_accum: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> state_q == bde_pkg::ST_ACCUM)
		else $error("tally finished while sequencer busy");

	a_fin_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |=> state_q == bde_pkg::ST_MUL_A)
		else $error("finished vector did not start the sequence");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> state_q == bde_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.undefined |-> out_ch.distance == '0)
		else $error("undefined result with nonzero distance");
`endif

endmodule
`default_nettype wire
